@@ rtl/ctsc_pkg.sv @@
`default_nettype none

package ctsc_pkg;

    localparam int MAX_TASKS    = 16;
    localparam int TICK_WIDTH   = 16;
    localparam int RESULT_LIMIT = 16;

    localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int RES_W  = $clog2(RESULT_LIMIT + 1);
    localparam int PEND_W = 8;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef struct packed {
        logic [7:0]            handle;
        logic [TICK_WIDTH-1:0] delay;
        logic [TICK_WIDTH-1:0] period;
        logic [PEND_W-1:0]     pending;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        REQ_ADD      = 3'd0,
        REQ_DELETE   = 3'd1,
        REQ_TICK     = 3'd2,
        REQ_DISPATCH = 3'd3,
        REQ_CLEAR    = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_TICK,
        OP_DISPATCH
    } t_op;

    typedef struct packed {
        logic ready;
        logic one_shot;
    } t_flags;

endpackage

`default_nettype wire

@@ rtl/ctsc_ram.sv @@
`default_nettype none

module ctsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ctsc_entry_alu.sv @@
`default_nettype none

module ctsc_entry_alu import ctsc_pkg::*; (
    input  wire t_op    i_op,
    input  wire t_entry i_entry,
    output t_entry      o_entry,
    output t_flags      o_flags
);

    logic [TICK_WIDTH-1:0] w_dec;

    always_comb begin
        w_dec   = (i_entry.delay != '0) ? i_entry.delay - TICK_WIDTH'(1) : '0;
        o_entry = i_entry;
        unique case (i_op)
            OP_TICK: begin
                o_entry.delay = w_dec;
                if (w_dec == '0) begin
                    if (i_entry.pending != PEND_MAX) begin
                        o_entry.pending = i_entry.pending + PEND_W'(1);
                    end
                    if (i_entry.period != '0) begin
                        o_entry.delay = i_entry.period;
                    end
                end
            end
            OP_DISPATCH: begin
                if (i_entry.pending != '0) begin
                    o_entry.pending = i_entry.pending - PEND_W'(1);
                end
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
        o_flags.ready    = (i_entry.pending != '0);
        o_flags.one_shot = (i_entry.period == '0);
    end

endmodule

`default_nettype wire

@@ rtl/cooperative_task_scheduler_core.sv @@
// add, clear all and unknown requests give their word from S_DONE into the output register once it is free
// tick walks the table at one entry per cycle through the task ram
// delete shifts later entries down one per cycle
// dispatch visits each entry through S_D_RD and S_D_EVAL, plus a shift walk for each one-shot removal
// one request in flight at a time; the next is accepted once the previous is finished
// reset empties the table (count to zero); ram entries are never read before written
`default_nettype none

module cooperative_task_scheduler_core import ctsc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_task_handle,
    input  wire logic [15:0] i_delay_ticks,
    input  wire logic [15:0] i_period_ticks,
    input  wire logic [3:0]  i_task_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [3:0]       o_task_id,
    output logic [7:0]       o_run_handle,
    output logic             o_task_ran,
    output logic             o_last
);

    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DONE,
        S_D_RD,
        S_D_EVAL,
        S_D_END
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    t_status            r_status, n_status;
    logic [3:0]         r_res_id, n_res_id;
    logic               r_shift, n_shift;
    logic               r_ret_disp, n_ret_disp;
    logic [CNT_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_lim, n_lim;
    logic               r_pipe_vld, n_pipe_vld;
    logic [IDX_W-1:0]   r_pipe_addr, n_pipe_addr;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [RES_W-1:0]   r_n, n_n;
    logic               r_hold_vld, n_hold_vld;
    logic [IDX_W-1:0]   r_hold_idx, n_hold_idx;
    logic [7:0]         r_hold_handle, n_hold_handle;
    logic               r_out_vld, n_out_vld;
    logic [1:0]         r_out_status, n_out_status;
    logic [3:0]         r_out_id, n_out_id;
    logic [7:0]         r_out_handle, n_out_handle;
    logic               r_out_ran, n_out_ran;
    logic               r_out_last, n_out_last;

    logic               w_we, w_re, w_accept, w_out_free;
    logic [IDX_W-1:0]   w_waddr, w_raddr;
    t_entry             w_wdata, w_rdata, w_alu_out;
    t_op                w_op;
    t_flags             w_flags;

    ctsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ctsc_entry_alu u_alu (
        .i_op    (w_op),
        .i_entry (w_rdata),
        .o_entry (w_alu_out),
        .o_flags (w_flags)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_out_free   = !r_out_vld || i_out_ready;
    assign o_out_valid  = r_out_vld;
    assign o_status     = r_out_status;
    assign o_task_id    = r_out_id;
    assign o_run_handle = r_out_handle;
    assign o_task_ran   = r_out_ran;
    assign o_last       = r_out_last;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_status      = r_status;
        n_res_id      = r_res_id;
        n_shift       = r_shift;
        n_ret_disp    = r_ret_disp;
        n_rd          = r_rd;
        n_lim         = r_lim;
        n_pipe_vld    = r_pipe_vld;
        n_pipe_addr   = r_pipe_addr;
        n_i           = r_i;
        n_n           = r_n;
        n_hold_vld    = r_hold_vld;
        n_hold_idx    = r_hold_idx;
        n_hold_handle = r_hold_handle;
        n_out_vld     = r_out_vld && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_id      = r_out_id;
        n_out_handle  = r_out_handle;
        n_out_ran     = r_out_ran;
        n_out_last    = r_out_last;
        w_we          = 1'b0;
        w_waddr       = '0;
        w_wdata       = w_alu_out;
        w_re          = 1'b0;
        w_raddr       = '0;
        w_op          = OP_PASS;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_res_id = '0;
                    n_state  = S_DONE;
                    unique case (i_req_type)
                        REQ_ADD: begin
                            if (r_count >= CNT_W'(MAX_TASKS)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we            = 1'b1;
                                w_waddr         = r_count[IDX_W-1:0];
                                w_wdata.handle  = i_task_handle;
                                w_wdata.delay   = TICK_WIDTH'(i_delay_ticks);
                                w_wdata.period  = TICK_WIDTH'(i_period_ticks);
                                w_wdata.pending = '0;
                                n_res_id        = 4'(r_count);
                                n_count         = r_count + CNT_W'(1);
                            end
                        end
                        REQ_DELETE: begin
                            if (CMP_W'(i_task_index) >= CMP_W'(r_count)) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                n_count    = r_count - CNT_W'(1);
                                n_rd       = CNT_W'(i_task_index) + CNT_W'(1);
                                n_lim      = r_count;
                                n_shift    = 1'b1;
                                n_ret_disp = 1'b0;
                                n_state    = S_WALK;
                            end
                        end
                        REQ_TICK: begin
                            n_rd       = '0;
                            n_lim      = r_count;
                            n_shift    = 1'b0;
                            n_ret_disp = 1'b0;
                            n_state    = S_WALK;
                        end
                        REQ_DISPATCH: begin
                            n_i        = '0;
                            n_n        = '0;
                            n_hold_vld = 1'b0;
                            n_state    = S_D_RD;
                        end
                        REQ_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_pipe_vld) begin
                    w_we    = 1'b1;
                    w_waddr = r_shift ? r_pipe_addr - IDX_W'(1) : r_pipe_addr;
                    w_op    = r_shift ? OP_PASS : OP_TICK;
                end
                if (r_rd < r_lim) begin
                    w_re        = 1'b1;
                    w_raddr     = r_rd[IDX_W-1:0];
                    n_rd        = r_rd + CNT_W'(1);
                    n_pipe_vld  = 1'b1;
                    n_pipe_addr = r_rd[IDX_W-1:0];
                end else begin
                    n_pipe_vld = 1'b0;
                    if (!r_pipe_vld) begin
                        n_state = r_ret_disp ? S_D_RD : S_DONE;
                    end
                end
            end
            S_D_RD: begin
                if (r_i < r_count && r_n < RES_W'(RESULT_LIMIT)) begin
                    w_re    = 1'b1;
                    w_raddr = r_i[IDX_W-1:0];
                    n_state = S_D_EVAL;
                end else begin
                    n_state = S_D_END;
                end
            end
            S_D_EVAL: begin
                w_op = OP_DISPATCH;
                if (!w_flags.ready) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_D_RD;
                end else if (!r_hold_vld || w_out_free) begin
                    if (r_hold_vld) begin
                        n_out_vld    = 1'b1;
                        n_out_status = ST_OK;
                        n_out_id     = 4'(r_hold_idx);
                        n_out_handle = r_hold_handle;
                        n_out_ran    = 1'b1;
                        n_out_last   = 1'b0;
                    end
                    n_hold_vld    = 1'b1;
                    n_hold_idx    = r_i[IDX_W-1:0];
                    n_hold_handle = w_rdata.handle;
                    n_n           = r_n + RES_W'(1);
                    if (!w_flags.one_shot) begin
                        w_we    = 1'b1;
                        w_waddr = r_i[IDX_W-1:0];
                        n_i     = r_i + CNT_W'(1);
                        n_state = S_D_RD;
                    end else begin
                        n_count    = r_count - CNT_W'(1);
                        n_rd       = r_i + CNT_W'(1);
                        n_lim      = r_count;
                        n_shift    = 1'b1;
                        n_ret_disp = 1'b1;
                        n_state    = S_WALK;
                    end
                end
            end
            S_D_END: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_id     = r_hold_vld ? 4'(r_hold_idx) : 4'd0;
                    n_out_handle = r_hold_vld ? r_hold_handle : 8'd0;
                    n_out_ran    = r_hold_vld;
                    n_out_last   = 1'b1;
                    n_hold_vld   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_id     = r_res_id;
                    n_out_handle = '0;
                    n_out_ran    = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pipe_vld <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_n        <= '0;
            r_rd       <= '0;
            r_lim      <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pipe_vld <= n_pipe_vld;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
            r_n        <= n_n;
            r_rd       <= n_rd;
            r_lim      <= n_lim;
        end
        r_status      <= n_status;
        r_res_id      <= n_res_id;
        r_shift       <= n_shift;
        r_ret_disp    <= n_ret_disp;
        r_pipe_addr   <= n_pipe_addr;
        r_i           <= n_i;
        r_hold_idx    <= n_hold_idx;
        r_hold_handle <= n_hold_handle;
        r_out_status  <= n_out_status;
        r_out_id      <= n_out_id;
        r_out_handle  <= n_out_handle;
        r_out_ran     <= n_out_ran;
        r_out_last    <= n_out_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TASKS))
        else $error("task count above table size");

    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RES_W'(RESULT_LIMIT))
        else $error("dispatch result count above limit");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_rd <= r_lim && r_lim <= CNT_W'(MAX_TASKS))
        else $error("walk pointer beyond its limit");

    a_hold_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> (r_state == S_D_RD || r_state == S_D_EVAL ||
                        r_state == S_D_END || r_state == S_WALK))
        else $error("held dispatch word outside a dispatch");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_out_vld && !i_out_ready |=> r_state == S_DONE)
        else $error("result left without room in output register");

endmodule

`default_nettype wire

@@ tb/cooperative_task_scheduler_core_test.sv @@
`timescale 1ns / 100ps

module cooperative_task_scheduler_core_test import ctsc_pkg::*; ();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int IDLE_PCT    = 16;

    typedef struct {
        logic [2:0]  req;
        logic [7:0]  handle;
        logic [15:0] delay;
        logic [15:0] period;
        logic [3:0]  index;
    } t_request;

    typedef struct {
        t_status     status;
        logic [3:0]  task_id;
        logic [7:0]  run_handle;
        logic        task_ran;
        logic        last;
    } t_reply;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_req_type     = '0;
    logic [7:0]  i_task_handle  = '0;
    logic [15:0] i_delay_ticks  = '0;
    logic [15:0] i_period_ticks = '0;
    logic [3:0]  i_task_index   = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_task_id;
    logic [7:0]  o_run_handle;
    logic        o_task_ran;
    logic        o_last;

    t_request    request_q[$];
    t_reply      reply_q[$];

    t_entry      sched_tbl[MAX_TASKS];
    int          n_tasks;

    int          n_sent     = 0;
    int          n_checked  = 0;
    int          n_ran      = 0;
    int          n_full     = 0;
    int          n_bad_idx  = 0;
    int          n_saturate = 0;
    int          n_fail     = 0;
    int          cycles     = 0;
    logic        steady;

    // no idling on either side for a stretch of the run
    assign steady = (n_sent >= 60) && (n_sent < 140);

    cooperative_task_scheduler_core u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic void push_reply(t_status st, logic [3:0] id, logic [7:0] h,
                                       logic ran, logic lst);
        t_reply r;
        r.status     = st;
        r.task_id    = id;
        r.run_handle = h;
        r.task_ran   = ran;
        r.last       = lst;
        reply_q.push_back(r);
    endfunction

    function automatic void drop_entry(int idx);
        int k;
        for (k = idx; k < n_tasks - 1; k++) begin
            sched_tbl[k] = sched_tbl[k + 1];
        end
        n_tasks--;
        sched_tbl[n_tasks] = '0;
    endfunction

    function automatic void run_scheduler(t_request rq);
        int i;
        int hits;
        hits = 0;
        case (rq.req)
            REQ_ADD: begin
                if (n_tasks >= MAX_TASKS) begin
                    push_reply(ST_FULL, '0, '0, 1'b0, 1'b1);
                    n_full++;
                end else begin
                    sched_tbl[n_tasks].handle  = rq.handle;
                    sched_tbl[n_tasks].delay   = rq.delay;
                    sched_tbl[n_tasks].period  = rq.period;
                    sched_tbl[n_tasks].pending = '0;
                    push_reply(ST_OK, IDX_W'(n_tasks), '0, 1'b0, 1'b1);
                    n_tasks++;
                end
            end
            REQ_DELETE: begin
                if (int'(rq.index) >= n_tasks) begin
                    push_reply(ST_BAD_INDEX, '0, '0, 1'b0, 1'b1);
                    n_bad_idx++;
                end else begin
                    drop_entry(int'(rq.index));
                    push_reply(ST_OK, '0, '0, 1'b0, 1'b1);
                end
            end
            REQ_TICK: begin
                for (i = 0; i < n_tasks; i++) begin
                    if (sched_tbl[i].delay != '0)
                        sched_tbl[i].delay = sched_tbl[i].delay - TICK_WIDTH'(1);
                    if (sched_tbl[i].delay == '0) begin
                        if (sched_tbl[i].pending != PEND_MAX)
                            sched_tbl[i].pending = sched_tbl[i].pending + PEND_W'(1);
                        else
                            n_saturate++;
                        if (sched_tbl[i].period != '0)
                            sched_tbl[i].delay = sched_tbl[i].period;
                    end
                end
                push_reply(ST_OK, '0, '0, 1'b0, 1'b1);
            end
            REQ_DISPATCH: begin
                i = 0;
                while (i < n_tasks && hits < RESULT_LIMIT) begin
                    if (sched_tbl[i].pending != '0) begin
                        push_reply(ST_OK, IDX_W'(i), sched_tbl[i].handle, 1'b1, 1'b0);
                        hits++;
                        n_ran++;
                        sched_tbl[i].pending = sched_tbl[i].pending - PEND_W'(1);
                        // one-shot leaves the table, next task slides into slot i
                        if (sched_tbl[i].period == '0) begin
                            drop_entry(i);
                            continue;
                        end
                    end
                    i++;
                end
                if (hits == 0)
                    push_reply(ST_OK, '0, '0, 1'b0, 1'b1);
                else
                    reply_q[reply_q.size() - 1].last = 1'b1;
            end
            REQ_CLEAR: begin
                for (i = 0; i < MAX_TASKS; i++) sched_tbl[i] = '0;
                n_tasks = 0;
                push_reply(ST_OK, '0, '0, 1'b0, 1'b1);
            end
            default: begin
                push_reply(ST_OK, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void queue_request(logic [2:0] req, logic [7:0] h, logic [15:0] d,
                                          logic [15:0] p, logic [3:0] idx);
        t_request rq;
        rq.req    = req;
        rq.handle = h;
        rq.delay  = d;
        rq.period = p;
        rq.index  = idx;
        request_q.push_back(rq);
    endfunction

    function automatic logic [15:0] pick_delay();
        if ($urandom_range(0, 9) < 8)
            return 16'($urandom_range(0, 4));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return '0;
        if (r < 8)
            return 16'($urandom_range(1, 5));
        return 16'($urandom);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rq.req    = i_req_type;
                rq.handle = i_task_handle;
                rq.delay  = i_delay_ticks;
                rq.period = i_period_ticks;
                rq.index  = i_task_index;
                run_scheduler(rq);
                n_sent <= n_sent + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    rq = request_q.pop_front();
                    i_req_type     <= rq.req;
                    i_task_handle  <= rq.handle;
                    i_delay_ticks  <= rq.delay;
                    i_period_ticks <= rq.period;
                    i_task_index   <= rq.index;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reply exp_w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked <= n_checked + 1;
                if (reply_q.size() == 0) begin
                    $error("word with none expected: status %0d task_id %0d", o_status, o_task_id);
                    n_fail++;
                end else begin
                    exp_w = reply_q.pop_front();
                    if (o_status !== exp_w.status) begin
                        $error("status: expected %0d, got %0d", exp_w.status, o_status);
                        n_fail++;
                    end
                    if (o_task_id !== exp_w.task_id) begin
                        $error("task_id: expected %0d, got %0d", exp_w.task_id, o_task_id);
                        n_fail++;
                    end
                    if (o_run_handle !== exp_w.run_handle) begin
                        $error("run_handle: expected %0d, got %0d",
                               exp_w.run_handle, o_run_handle);
                        n_fail++;
                    end
                    if (o_task_ran !== exp_w.task_ran) begin
                        $error("task_ran: expected %0d, got %0d", exp_w.task_ran, o_task_ran);
                        n_fail++;
                    end
                    if (o_last !== exp_w.last) begin
                        $error("last: expected %0d, got %0d", exp_w.last, o_last);
                        n_fail++;
                    end
                end
            end
            i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int made;
        int pick;
        int n;
        int k;

        n_tasks = 0;
        for (k = 0; k < MAX_TASKS; k++) sched_tbl[k] = '0;

        // directed
        queue_request(REQ_ADD, 8'hFF, 16'h0000, 16'h0000, 4'h0);
        queue_request(REQ_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 4'hF);
        queue_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_request(REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_request(REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 4'hF);
        queue_request(REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_request(3'd5, 8'hA5, 16'h1234, 16'h4321, 4'h3);
        queue_request(REQ_CLEAR, 8'h00, 16'h0000, 16'h0000, 4'h0);
        for (k = 0; k < MAX_TASKS; k++) begin
            queue_request(REQ_ADD, 8'(8'h10 + k), 16'(k % 2),
                          (k % 4 == 0) ? 16'h0000 : ((k % 4 == 1) ? 16'hFFFF : 16'(k)),
                          4'(k));
        end
        queue_request(REQ_ADD, 8'h77, 16'h0001, 16'h0001, 4'h0);
        queue_request(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 4'h0);
        queue_request(REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'h0);

        // random sequences
        made = 0;
        while (made < 150) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                n = $urandom_range(1, 5);
                repeat (n) queue_request(REQ_ADD, 8'($urandom), pick_delay(), pick_period(),
                                         4'($urandom));
                made += n;
            end else if (pick < 55) begin
                n = $urandom_range(1, 4);
                repeat (n) queue_request(REQ_TICK, 8'($urandom), 16'($urandom),
                                         16'($urandom), 4'($urandom));
                made += n;
            end else if (pick < 75) begin
                queue_request(REQ_DISPATCH, 8'($urandom), 16'($urandom), 16'($urandom),
                              4'($urandom));
                made++;
            end else if (pick < 87) begin
                queue_request(REQ_DELETE, 8'($urandom), 16'($urandom), 16'($urandom),
                              ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 5))
                                                         : 4'($urandom));
                made++;
            end else if (pick < 91) begin
                queue_request(REQ_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                              4'($urandom));
                made++;
            end else if (pick < 95) begin
                queue_request(3'($urandom_range(5, 7)), 8'($urandom), 16'($urandom),
                              16'($urandom), 4'($urandom));
                made++;
            end else begin
                queue_request(REQ_ADD, 8'($urandom), 16'($urandom), 16'($urandom),
                              4'($urandom));
                made++;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (request_q.size() != 0 || i_in_valid || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d requests and %0d reply words, %0d task runs dispatched",
                 n_sent, n_checked, n_ran);
        $display("table-full adds %0d, bad-index deletes %0d, saturated ticks %0d",
                 n_full, n_bad_idx, n_saturate);
        if (n_fail == 0 && reply_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
